/* hdl/sctm_pkg.sv */
// Shared types, constants and helpers for the sector cache tag manager.
package sctm_pkg;

  localparam int SlotsDef        = 32;
  localparam int MaxSlotShiftDef = 3;
  localparam int FlushCap        = 32;
  localparam int MinSegLen       = 8;

  localparam logic signed [31:0] ScoreMax  = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] ScoreMin  = 32'sh8000_0000;
  localparam logic signed [31:0] MinStart  = 32'sh0FFF_FFFF;
  localparam logic [31:0]        EmptyBase = 32'hFFFF_FFF0;

  typedef enum logic [1:0] {
    OP_READ  = 2'd0,
    OP_ALLOC = 2'd1,
    OP_WRITE = 2'd2,
    OP_FLUSH = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_UPDATE,
    ST_PICK,
    ST_FLUSH,
    ST_EMIT
  } state_t;

  // Command from the control unit to every cell
  typedef struct packed {
    logic        age;      // read or allocate: aging pass
    logic        mark;     // write: mark the selected slot dirty
    logic        install;  // miss: install the victim
    logic        clean;    // clear dirty mark of the selected slot
    logic [31:0] aligned;
    logic [1:0]  shift;
  } cell_cmd_t;

  // Saturating add of a small signed delta to a 32-bit score
  function automatic logic signed [31:0] score_add(input logic signed [31:0] s,
                                                   input logic signed [2:0] d);
    logic signed [32:0] r;
    r = 33'(s) + 33'(d);
    if (r > 33'(ScoreMax)) return ScoreMax;
    if (r < 33'(ScoreMin)) return ScoreMin;
    return r[31:0];
  endfunction

endpackage

/* hdl/sctm_cell.sv */
// One cache slot: tag, aging score, dirty mark, and a link of the min/dirty chain.
module sctm_cell
  import sctm_pkg::*;
#(
  parameter int IdxW   = 5,
  parameter bit RegOut = 1'b0
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  cell_cmd_t               cmd,
  input  logic                    sel,          // this cell is the chosen slot
  input  logic [31:0]             sector,
  // chain in from the lower neighbor (min registered at segment ends)
  input  logic signed [31:0]      min_in,
  input  logic [IdxW-1:0]         min_idx_in,
  input  logic                    dirty_in,     // any lower cell dirty
  input  logic [IdxW-1:0]         my_idx,
  output logic signed [31:0]      min_out,
  output logic [IdxW-1:0]         min_idx_out,
  output logic                    dirty_out,
  output logic                    match,
  output logic                    dirty,
  output logic                    first_dirty,
  output logic [31:0]             base
);

  logic [31:0]        base_r;
  logic signed [31:0] score_r, score_nxt;
  logic               dirty_r, valid_r;
  logic [32:0]        lim;
  logic signed [31:0] min_w;
  logic [IdxW-1:0]    min_idx_w;

  assign lim   = 33'(base_r) + (33'd1 << cmd.shift);
  assign match = valid_r && (sector >= base_r) && (33'(sector) < lim);
  assign dirty = dirty_r;
  assign base  = base_r;
  assign first_dirty = dirty_r && !dirty_in;
  assign dirty_out   = dirty_r || dirty_in;

  // strict less keeps the first minimum
  always_comb begin
    if (score_r < min_in) begin
      min_w = score_r;
      min_idx_w = my_idx;
    end else begin
      min_w = min_in;
      min_idx_w = min_idx_in;
    end
  end

  if (RegOut) begin : g_reg
    logic signed [31:0] min_r;
    logic [IdxW-1:0]    min_idx_r;
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        min_r <= MinStart;
        min_idx_r <= '0;
      end else begin
        min_r <= min_w;
        min_idx_r <= min_idx_w;
      end
    end
    assign min_out = min_r;
    assign min_idx_out = min_idx_r;
  end else begin : g_comb
    assign min_out = min_w;
    assign min_idx_out = min_idx_w;
  end

  always_comb begin
    score_nxt = score_r;
    if (cmd.age) begin
      if (match) score_nxt = score_add(score_add((score_r < 0) ? 32'sd0 : score_r, 3'sd2),
                                       -3'sd1);
      else       score_nxt = score_add(score_r, -3'sd1);
    end else if ((cmd.install || cmd.mark) && sel) begin
      score_nxt = score_add(score_r, 3'sd2);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      score_r <= '0;
      dirty_r <= 1'b0;
      valid_r <= 1'b0;
      base_r  <= EmptyBase;
    end else begin
      score_r <= score_nxt;
      if (sel && cmd.mark) dirty_r <= 1'b1;
      else if (sel && cmd.clean) dirty_r <= 1'b0;
      if (sel && cmd.install) begin
        base_r  <= cmd.aligned;
        valid_r <= 1'b1;
      end
    end
  end

endmodule

/* hdl/sctm_chain.sv */
// Row of slot cells; the min scan is registered every few cells, match/dirty scans are direct.
module sctm_chain
  import sctm_pkg::*;
#(
  parameter int Slots = SlotsDef,
  parameter int IdxW  = $clog2(Slots)
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  cell_cmd_t            cmd,
  input  logic [IdxW-1:0]      sel_idx,
  input  logic                 sel_en,
  input  logic [31:0]          sector,
  output logic                 any_match,
  output logic [IdxW-1:0]      last_match,
  output logic [IdxW-1:0]      first_match_idx,
  output logic [IdxW-1:0]      min_idx,
  output logic                 any_dirty,
  output logic [IdxW-1:0]      dirty_idx,
  output logic [31:0]          sel_base,
  output logic                 sel_dirty
);

  logic signed [31:0] min_c   [Slots+1];
  logic [IdxW-1:0]    midx_c  [Slots+1];
  logic               dchain  [Slots+1];
  logic [Slots-1:0]   match_v, dirty_v, fdirty_v;
  logic [31:0]        base_v  [Slots];

  assign min_c[0]  = MinStart;
  assign midx_c[0] = '0;
  assign dchain[0] = 1'b0;

  for (genvar g = 0; g < Slots; g++) begin : g_cell
    sctm_cell #(
      .IdxW  (IdxW),
      .RegOut(((g % MinSegLen) == MinSegLen - 1) && (g != Slots - 1))
    ) u_cell (
      .clk, .rst_n, .cmd,
      .sel        (sel_en && (sel_idx == IdxW'(g))),
      .sector,
      .min_in     (min_c[g]),
      .min_idx_in (midx_c[g]),
      .dirty_in   (dchain[g]),
      .my_idx     (IdxW'(g)),
      .min_out    (min_c[g+1]),
      .min_idx_out(midx_c[g+1]),
      .dirty_out  (dchain[g+1]),
      .match      (match_v[g]),
      .dirty      (dirty_v[g]),
      .first_dirty(fdirty_v[g]),
      .base       (base_v[g])
    );
  end

  always_comb begin
    last_match = '0;
    first_match_idx = '0;
    dirty_idx = '0;
    for (int i = Slots - 1; i >= 0; i--) begin
      if (match_v[i]) first_match_idx = IdxW'(i);
      if (fdirty_v[i]) dirty_idx = IdxW'(i);
    end
    for (int i = 0; i < Slots; i++)
      if (match_v[i]) last_match = IdxW'(i);
  end

  assign any_match = |match_v;
  assign any_dirty = dchain[Slots];
  assign min_idx   = midx_c[Slots];
  assign sel_base  = base_v[sel_idx];
  assign sel_dirty = dirty_v[sel_idx];

endmodule

/* hdl/sector_cache_tag_manager.sv */
// Hit and write: the item passes ST_UPDATE, then ST_EMIT; the next item is accepted back in ST_IDLE.
// Miss: the victim search walks the min chain one 8-slot segment per cycle in ST_PICK, then
// ST_EMIT gives the result; no new item is taken before the block is back in ST_IDLE.
// Flush: one result per dirty slot per cycle while the output is free, then a summary.
// Output stalls hold the block in ST_FLUSH or ST_EMIT.
// Synchronous active-low reset empties all slots, clears scores, counters, dirty
// marks, sets slot_shift to 3.
module sector_cache_tag_manager
  import sctm_pkg::*;
#(
  parameter int Slots        = SlotsDef,
  parameter int MaxSlotShift = MaxSlotShiftDef
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [7:0]   cfg_data,      // [1:0] slot_shift
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [39:0]  in_tdata,      // [1:0] op, [33:2] sector
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [151:0] out_tdata,     // hit, buffer_index, evict_valid, evict_sector,
                                      // evict_slot, fetch_valid, fetch_sector, status,
                                      // flush_count, access_count, hit_count
  output logic         out_tlast
);

  localparam int IdxW = $clog2(Slots);
  localparam int PickCycles = (Slots + MinSegLen - 1) / MinSegLen;

  logic [1:0]  shift_cfg_r;
  logic [1:0]  shift;
  state_t      state_r, state_nxt;
  op_t         op_r;
  logic [31:0] sector_r;
  logic [31:0] acc_r, hits_r;
  logic [6:0]  nflush_r;
  logic        out_valid_r;
  logic [151:0] out_data_r;
  logic [151:0] miss_data_r;
  logic        out_last_r;
  cell_cmd_t   cmd;
  logic [IdxW-1:0] sel_idx;
  logic        sel_en;
  logic        any_match, any_dirty, sel_dirty;
  logic [IdxW-1:0] last_match, first_m, min_idx, dirty_idx;
  logic [31:0] sel_base, aligned;
  logic [IdxW-1:0] hold_idx_r;
  logic        hit_r;
  logic [3:0]  pick_cnt_r;
  logic        pick_last;

  assign shift   = (32'(shift_cfg_r) > MaxSlotShift) ? 2'(MaxSlotShift) : shift_cfg_r;
  assign aligned = (sector_r >> shift) << shift;
  assign cfg_ready = 1'b1;
  assign in_tready = (state_r == ST_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;
  // min chain has settled through every segment
  assign pick_last  = (pick_cnt_r == 4'(PickCycles - 1));

  logic out_free;
  assign out_free = !out_valid_r || out_tready;

  sctm_chain #(.Slots(Slots), .IdxW(IdxW)) u_chain (
    .clk, .rst_n, .cmd, .sel_idx, .sel_en, .sector(sector_r),
    .any_match, .last_match, .first_match_idx(first_m), .min_idx,
    .any_dirty, .dirty_idx, .sel_base, .sel_dirty
  );

  function automatic logic [151:0] pack(
    input logic hit, input logic [7:0] bi, input logic ev, input logic [31:0] es,
    input logic [4:0] eslot, input logic fv, input logic [31:0] fs, input logic st,
    input logic [5:0] fc, input logic [31:0] ac, input logic [31:0] hc);
    return {1'b0, hc, ac, fc, st, fs, fv, eslot, es, ev, bi, hit};
  endfunction

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE:   if (in_tvalid) state_nxt = (op_t'(in_tdata[1:0]) == OP_FLUSH) ? ST_FLUSH
                                                                              : ST_UPDATE;
      ST_UPDATE: if (op_r == OP_WRITE) state_nxt = ST_EMIT;
                 else state_nxt = any_match ? ST_EMIT : ST_PICK;
      ST_PICK:   if (pick_last) state_nxt = ST_EMIT;
      ST_FLUSH:  if (out_free && (!any_dirty || nflush_r == 7'(FlushCap))) state_nxt = ST_EMIT;
      ST_EMIT:   if (out_free) state_nxt = ST_IDLE;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  // cell commands
  always_comb begin
    cmd = '0;
    cmd.shift = shift;
    cmd.aligned = aligned;
    sel_idx = hold_idx_r;
    sel_en = 1'b0;
    case (state_r)
      ST_UPDATE: begin
        if (op_r == OP_WRITE) begin
          cmd.mark = any_match;
          sel_idx = first_m;
          sel_en = any_match;
        end else begin
          cmd.age = 1'b1;
        end
      end
      ST_PICK: begin
        cmd.install = pick_last;
        cmd.clean = pick_last;
        sel_idx = min_idx;
        sel_en = pick_last;
      end
      ST_FLUSH: begin
        sel_idx = dirty_idx;
        cmd.clean = 1'b1;
        sel_en = out_free && any_dirty && (nflush_r != 7'(FlushCap));
      end
      ST_EMIT: sel_idx = hold_idx_r;
      default: ;
    endcase
  end

  logic [7:0] bidx;
  assign bidx = 8'((32'(sel_idx) << shift) + (sector_r - ((op_r == OP_WRITE || hit_r)
                                                          ? sel_base : aligned)));

  logic emit_fire;
  assign emit_fire = ((state_r == ST_EMIT) && out_free) || ((state_r == ST_FLUSH) && sel_en);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      shift_cfg_r <= 2'd3;
      acc_r <= '0;
      hits_r <= '0;
      out_valid_r <= 1'b0;
      nflush_r <= '0;
      hit_r <= 1'b0;
      pick_cnt_r <= '0;
    end else begin
      state_r <= state_nxt;
      if (cfg_valid) shift_cfg_r <= cfg_data[1:0];
      if (emit_fire) out_valid_r <= 1'b1;
      else if (out_tready) out_valid_r <= 1'b0;
      case (state_r)
        ST_IDLE: if (in_tvalid) begin
          op_r <= op_t'(in_tdata[1:0]);
          sector_r <= in_tdata[33:2];
          nflush_r <= '0;
          hit_r <= 1'b0;
        end
        ST_UPDATE: begin
          hit_r <= any_match;
          hold_idx_r <= (op_r == OP_WRITE) ? first_m : last_match;
          pick_cnt_r <= '0;
          if (op_r == OP_READ) begin
            acc_r <= acc_r + 32'd1;
            if (any_match) hits_r <= hits_r + 32'd1;
          end
          // write and hit results are built in ST_EMIT from the held slot
        end
        ST_PICK: begin
          pick_cnt_r <= pick_cnt_r + 4'd1;
          if (pick_last) begin
            hold_idx_r <= min_idx;
            // hold the miss result here; the output register may still be busy
            miss_data_r <= pack(1'b0, bidx, sel_dirty, sel_dirty ? sel_base : 32'd0,
                                sel_dirty ? 5'(min_idx) : 5'd0,
                                op_r == OP_READ, (op_r == OP_READ) ? aligned : 32'd0,
                                1'b0, 6'd0, acc_r, hits_r);
          end
        end
        ST_FLUSH: if (sel_en) begin
          out_last_r <= 1'b0;
          out_data_r <= pack(1'b0, 8'd0, 1'b1, sel_base, 5'(dirty_idx), 1'b0, 32'd0,
                             1'b0, 6'd0, acc_r, hits_r);
          nflush_r <= nflush_r + 7'd1;
        end
        ST_EMIT: if (out_free) begin
          out_last_r <= 1'b1;
          if (op_r == OP_FLUSH)
            out_data_r <= pack(1'b0, 8'd0, 1'b0, 32'd0, 5'd0, 1'b0, 32'd0, 1'b0,
                               6'(nflush_r), acc_r, hits_r);
          else if (hit_r)
            out_data_r <= pack(1'b1, bidx, 1'b0, 32'd0, 5'd0, 1'b0, 32'd0, 1'b0, 6'd0,
                               acc_r, hits_r);
          else if (op_r == OP_WRITE)
            out_data_r <= pack(1'b0, 8'd0, 1'b0, 32'd0, 5'd0, 1'b0, 32'd0, 1'b1, 6'd0,
                               acc_r, hits_r);
          else
            out_data_r <= miss_data_r;
        end
        default: ;
      endcase
    end
  end

  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != ST_IDLE) |-> !in_tready) else $error("accept while busy");
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_tready) |=> out_valid_r) else $error("result dropped");
  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_FLUSH) |-> (nflush_r <= 7'(FlushCap))) else $error("flush overrun");

endmodule

/* test/sctm_checker.sv */
// Checker for the sector cache tag manager: predicts every result item and compares it.
module sctm_checker
  import sctm_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  logic         cfg_valid,
  input  logic         cfg_ready,
  input  logic [7:0]   cfg_data,
  input  logic         in_tvalid,
  input  logic         in_tready,
  input  logic [39:0]  in_tdata,
  input  logic         out_tvalid,
  input  logic         out_tready,
  input  logic [151:0] out_tdata,
  input  logic         out_tlast,
  output int           errors,
  output int           pending,
  output int           results_seen
);

  typedef struct packed {
    logic        hit;
    logic [7:0]  buffer_index;
    logic        evict_valid;
    logic [31:0] evict_sector;
    logic [4:0]  evict_slot;
    logic        fetch_valid;
    logic [31:0] fetch_sector;
    logic        status;
    logic [5:0]  flush_count;
    logic [31:0] access_count;
    logic [31:0] hit_count;
    logic        last;
  } cache_result_t;

  logic [31:0]        base_q [SlotsDef];
  logic signed [31:0] score_q [SlotsDef];
  logic               dirty_q [SlotsDef];
  logic               valid_q [SlotsDef];
  logic [31:0]        reads_q, hits_q;
  logic [1:0]         shift_q;
  cache_result_t      expected_q [$];

  assign pending = expected_q.size();

  function automatic logic signed [31:0] sat_add(logic signed [31:0] s, int d);
    longint r;
    r = longint'(s) + d;
    if (r > 64'sd2147483647) r = 64'sd2147483647;
    if (r < -64'sd2147483648) r = -64'sd2147483648;
    return r[31:0];
  endfunction

  function automatic logic covers(int i, logic [31:0] sector);
    return valid_q[i] && sector >= base_q[i] &&
           {1'b0, sector} < {1'b0, base_q[i]} + (33'd1 << shift_q);
  endfunction

  function automatic logic [7:0] buf_pos(int slot, logic [31:0] offset);
    logic [31:0] p;
    p = (32'(slot) << shift_q) + offset;
    return p[7:0];
  endfunction

  function automatic cache_result_t blank();
    cache_result_t r;
    r = '0;
    r.access_count = reads_q;
    r.hit_count = hits_q;
    return r;
  endfunction

  function automatic void predict_lookup(logic is_read, logic [31:0] sector);
    int found, victim;
    logic signed [31:0] least;
    logic [31:0] aligned;
    cache_result_t r;
    found = -1;
    victim = 0;
    least = MinStart;
    aligned = (sector >> shift_q) << shift_q;
    if (is_read) reads_q++;
    for (int i = 0; i < SlotsDef; i++) begin
      if (covers(i, sector)) begin
        if (score_q[i] < 0) score_q[i] = 0;
        score_q[i] = sat_add(score_q[i], 2);
        found = i;
      end
      score_q[i] = sat_add(score_q[i], -1);
    end
    if (found >= 0) begin
      if (is_read) hits_q++;
      r = blank();
      r.hit = 1'b1;
      r.buffer_index = buf_pos(found, sector - base_q[found]);
      r.last = 1'b1;
      expected_q.push_back(r);
      return;
    end
    for (int i = 0; i < SlotsDef; i++)
      if (score_q[i] < least) begin
        least = score_q[i];
        victim = i;
      end
    r = blank();
    if (dirty_q[victim]) begin
      r.evict_valid = 1'b1;
      r.evict_sector = base_q[victim];
      r.evict_slot = victim[4:0];
      dirty_q[victim] = 1'b0;
    end
    score_q[victim] = sat_add(score_q[victim], 2);
    base_q[victim] = aligned;
    valid_q[victim] = 1'b1;
    r.buffer_index = buf_pos(victim, sector - aligned);
    if (is_read) begin
      r.fetch_valid = 1'b1;
      r.fetch_sector = aligned;
    end
    r.last = 1'b1;
    expected_q.push_back(r);
  endfunction

  function automatic void predict_item(op_t op, logic [31:0] sector);
    int found, n;
    cache_result_t r;
    case (op)
      OP_READ, OP_ALLOC: predict_lookup(op == OP_READ, sector);
      OP_WRITE: begin
        found = -1;
        for (int i = 0; i < SlotsDef && found < 0; i++)
          if (covers(i, sector)) found = i;
        r = blank();
        if (found < 0) begin
          r.status = 1'b1;
        end else begin
          score_q[found] = sat_add(score_q[found], 2);
          dirty_q[found] = 1'b1;
          r.hit = 1'b1;
          r.buffer_index = buf_pos(found, sector - base_q[found]);
        end
        r.last = 1'b1;
        expected_q.push_back(r);
      end
      default: begin
        n = 0;
        for (int i = 0; i < SlotsDef && n < FlushCap; i++)
          if (dirty_q[i]) begin
            r = blank();
            r.evict_valid = 1'b1;
            r.evict_sector = base_q[i];
            r.evict_slot = i[4:0];
            dirty_q[i] = 1'b0;
            expected_q.push_back(r);
            n++;
          end
        r = blank();
        r.flush_count = n[5:0];
        r.last = 1'b1;
        expected_q.push_back(r);
      end
    endcase
  endfunction

  function automatic void check_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, exp_v, act_v);
      errors++;
    end
  endfunction

  function automatic void check_result();
    cache_result_t e;
    if (expected_q.size() == 0) begin
      $error("result item with nothing expected: tdata 0x%0h", out_tdata);
      errors++;
      return;
    end
    e = expected_q.pop_front();
    check_field("hit", e.hit, out_tdata[0]);
    check_field("buffer_index", e.buffer_index, out_tdata[8:1]);
    check_field("evict_valid", e.evict_valid, out_tdata[9]);
    check_field("evict_sector", e.evict_sector, out_tdata[41:10]);
    check_field("evict_slot", e.evict_slot, out_tdata[46:42]);
    check_field("fetch_valid", e.fetch_valid, out_tdata[47]);
    check_field("fetch_sector", e.fetch_sector, out_tdata[79:48]);
    check_field("status", e.status, out_tdata[80]);
    check_field("flush_count", e.flush_count, out_tdata[86:81]);
    check_field("access_count", e.access_count, out_tdata[118:87]);
    check_field("hit_count", e.hit_count, out_tdata[150:119]);
    check_field("last", e.last, out_tlast);
  endfunction

  initial begin
    errors = 0;
    results_seen = 0;
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < SlotsDef; i++) begin
        base_q[i] = EmptyBase;
        score_q[i] = '0;
        dirty_q[i] = 1'b0;
        valid_q[i] = 1'b0;
      end
      reads_q = '0;
      hits_q = '0;
      shift_q = 2'd3;
      expected_q.delete();
    end else begin
      // Results first: a result never follows its own item in the same cycle.
      if (out_tvalid && out_tready) begin
        check_result();
        results_seen++;
      end
      if (cfg_valid && cfg_ready) shift_q = cfg_data[1:0];
      if (in_tvalid && in_tready) predict_item(op_t'(in_tdata[1:0]), in_tdata[33:2]);
    end
  end

endmodule

/* test/tb.sv */
// Testbench top for the sector cache tag manager: stimulus, pacing and verdict.
module tb;
  import sctm_pkg::*;

  logic         clk = 1'b0;
  logic         rst_n = 1'b0;
  logic         cfg_valid = 1'b0;
  logic         cfg_ready;
  logic [7:0]   cfg_data = '0;
  logic         in_tvalid = 1'b0;
  logic         in_tready;
  logic [39:0]  in_tdata = '0;
  logic         out_tvalid;
  logic         out_tready = 1'b0;
  logic [151:0] out_tdata;
  logic         out_tlast;
  int           errors, pending, results_seen;
  int           items_sent = 0;
  logic         quiet = 1'b0;
  logic         stall_done = 1'b0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  sector_cache_tag_manager dut (.*);

  sctm_checker chk (.*);

  initial begin
    #8_000_000;
    $display("FAIL sector_cache_tag_manager");
    $finish;
  end

  // Receiver: random holds until quiet is set, one long hold once 60 items have been sent
  initial begin
    @(posedge clk iff rst_n);
    forever begin
      if (!stall_done && items_sent >= 60) begin
        out_tready <= 1'b0;
        repeat (200) @(posedge clk);
        stall_done = 1'b1;
      end else if (!quiet && $urandom_range(3) == 0) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(5, 1)) @(posedge clk);
      end else begin
        out_tready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  task automatic send_item(op_t op, logic [31:0] sector);
    in_tdata <= {6'b0, sector, op};
    in_tvalid <= 1'b1;
    do @(posedge clk); while (!in_tready);
    items_sent++;
    if (!quiet && $urandom_range(3) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(5, 1)) @(posedge clk);
    end
  endtask

  // Wait for the block to drain
  task automatic drain();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic set_shift(logic [1:0] shift);
    drain();
    cfg_data <= {6'b0, shift};
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [31:0] pick_sector();
    logic [31:0] blk;
    int r;
    r = $urandom_range(99);
    if (r < 15) return $urandom();
    blk = $urandom_range(47);
    // Near the top of the sector space or the bottom, both with a random offset
    if (r < 35) return 32'hFFFF_FFFF - (blk << 3) - $urandom_range(7);
    return (blk << 3) + $urandom_range(7);
  endfunction

  function automatic op_t pick_op();
    int r;
    r = $urandom_range(99);
    if (r < 40) return OP_READ;
    if (r < 60) return OP_ALLOC;
    if (r < 92) return OP_WRITE;
    return OP_FLUSH;
  endfunction

  initial begin
    logic [1:0] shifts [4];
    shifts = '{2'd0, 2'd2, 2'd1, 2'd3};
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: empty flush, unallocated write, hits, top of sector space
    send_item(OP_FLUSH, 32'h0);
    send_item(OP_WRITE, 32'h5);
    send_item(OP_READ, 32'h0);
    send_item(OP_READ, 32'h7);
    send_item(OP_WRITE, 32'h3);
    send_item(OP_ALLOC, 32'hFFFF_FFFF);
    send_item(OP_READ, 32'hFFFF_FFF8);
    send_item(OP_WRITE, 32'hFFFF_FFFC);
    send_item(OP_READ, 32'h1234_5678);
    send_item(OP_ALLOC, 32'hAAAA_AAAA);
    send_item(OP_WRITE, 32'hAAAA_AAAD);
    send_item(OP_READ, 32'h5555_5555);
    send_item(OP_FLUSH, 32'hFFFF_FFFF);
    send_item(OP_FLUSH, 32'h0);
    send_item(OP_WRITE, 32'h8);

    // Random phases, each under its own block size; the shift change also
    // leaves overlapping slots behind, so several can match one sector
    for (int p = 0; p < 4; p++) begin
      set_shift(shifts[p]);
      for (int k = 0; k < 88; k++) begin
        if (p == 3 && k >= 50) quiet = 1'b1;
        send_item(pick_op(), pick_sector());
      end
      send_item(OP_FLUSH, $urandom());
    end

    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    $display("Ran %0d items over block sizes 1, 2, 4 and 8 sectors, %0d results checked.",
             items_sent, results_seen);
    if (errors == 0) $display("PASS sector_cache_tag_manager");
    else $display("FAIL sector_cache_tag_manager");
    $finish;
  end

endmodule
